// ===== hdl/jqpm_pkg.sv =====
// shared types, constants and the control program for the joystick position map
// used by jqpm_seq, jqpm_dp and joystick_quadratic_position_map_core
package jqpm_pkg;

    // default converter width and fixed constants of the curve
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int POS_MAX         = 100;
    localparam int SAT_LIMIT       = 101;
    localparam int COARSE_DIV      = 10;
    localparam int POS_BITS        = 8;
    localparam int QUO_BITS        = 7;
    localparam int DIV_STEPS       = 7;
    localparam int CNT_BITS        = 3;
    localparam int PC_BITS         = 4;
    localparam int CFG_INDEX_BITS  = 2;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LOW  = 2'd0,
        REG_MID  = 2'd1,
        REG_HIGH = 2'd2,
        REG_FLIP = 2'd3
    } reg_idx_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_MIRROR    = 4'd1,
        OP_COARSE_X  = 4'd2,
        OP_COARSE_M  = 4'd3,
        OP_COARSE_E  = 4'd4,
        OP_DIFF      = 4'd5,
        OP_SQ_Q      = 4'd6,
        OP_SQ_D      = 4'd7,
        OP_SCALE     = 4'd8,
        OP_LIMIT     = 4'd9,
        OP_DIV_INIT  = 4'd10,
        OP_DIV_STEP  = 4'd11,
        OP_SIGN      = 4'd12,
        OP_ZERO_SPAN = 4'd13,
        OP_SATURATE  = 4'd14
    } op_t;

    // sequencer jump kinds
    typedef enum logic [2:0] {
        JMP_NONE     = 3'd0,
        JMP_ALWAYS   = 3'd1,
        JMP_DEN_ZERO = 3'd2,
        JMP_SAT      = 3'd3,
        JMP_CNT_NZ   = 3'd4,
        JMP_DONE     = 3'd5
    } jmp_t;

    // one control word of the program
    typedef struct packed {
        op_t                op;
        jmp_t               jmp;
        logic [PC_BITS-1:0] target;
    } cw_t;

    // control from sequencer to datapath
    typedef struct packed {
        logic en;
        op_t  op;
    } ctl_t;

    // status from datapath to sequencer
    typedef struct packed {
        logic den_zero;
        logic sat;
        logic cnt_nz;
    } stat_t;

    // program step labels
    localparam logic [PC_BITS-1:0] STEP_START = 4'd0;
    localparam logic [PC_BITS-1:0] STEP_DIV   = 4'd10;
    localparam logic [PC_BITS-1:0] STEP_SIGN  = 4'd11;
    localparam logic [PC_BITS-1:0] STEP_ZERO  = 4'd12;
    localparam logic [PC_BITS-1:0] STEP_SAT   = 4'd13;
    localparam logic [PC_BITS-1:0] STEP_LAST  = 4'd13;

    // control program
    function automatic cw_t jqpm_rom(input logic [PC_BITS-1:0] pc);
        cw_t cw;
        cw = '{op: OP_NOP, jmp: JMP_ALWAYS, target: STEP_SIGN};
        unique case (pc)
            4'd0:    cw = '{op: OP_MIRROR,    jmp: JMP_NONE,     target: STEP_START};
            4'd1:    cw = '{op: OP_COARSE_X,  jmp: JMP_NONE,     target: STEP_START};
            4'd2:    cw = '{op: OP_COARSE_M,  jmp: JMP_NONE,     target: STEP_START};
            4'd3:    cw = '{op: OP_COARSE_E,  jmp: JMP_NONE,     target: STEP_START};
            4'd4:    cw = '{op: OP_DIFF,      jmp: JMP_NONE,     target: STEP_START};
            4'd5:    cw = '{op: OP_SQ_Q,      jmp: JMP_NONE,     target: STEP_START};
            4'd6:    cw = '{op: OP_SQ_D,      jmp: JMP_NONE,     target: STEP_START};
            4'd7:    cw = '{op: OP_SCALE,     jmp: JMP_DEN_ZERO, target: STEP_ZERO};
            4'd8:    cw = '{op: OP_LIMIT,     jmp: JMP_NONE,     target: STEP_START};
            4'd9:    cw = '{op: OP_DIV_INIT,  jmp: JMP_SAT,      target: STEP_SAT};
            4'd10:   cw = '{op: OP_DIV_STEP,  jmp: JMP_CNT_NZ,   target: STEP_DIV};
            4'd11:   cw = '{op: OP_SIGN,      jmp: JMP_DONE,     target: STEP_START};
            4'd12:   cw = '{op: OP_ZERO_SPAN, jmp: JMP_ALWAYS,   target: STEP_SIGN};
            4'd13:   cw = '{op: OP_SATURATE,  jmp: JMP_ALWAYS,   target: STEP_SIGN};
            default: cw = '{op: OP_NOP,       jmp: JMP_ALWAYS,   target: STEP_SIGN};
        endcase
        return cw;
    endfunction

endpackage

// ===== hdl/jqpm_seq.sv =====
// microcode sequencer: step counter, program table lookup and conditional jumps
// depends on jqpm_pkg
module jqpm_seq
    import jqpm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  hold,
    input  stat_t st,
    output ctl_t  ctl,
    output logic  busy,
    output logic  fin
);

    logic               busy_reg, busy_next;
    logic [PC_BITS-1:0] pc_reg, pc_next;
    logic [PC_BITS-1:0] pc_inc;
    cw_t                cw;
    logic               wait_out;

    // current control word
    assign cw       = jqpm_rom(pc_reg);
    assign pc_inc   = pc_reg + 1'b1;
    assign wait_out = (cw.jmp == JMP_DONE) && hold;

    assign ctl.en = busy_reg && !wait_out;
    assign ctl.op = cw.op;
    assign busy   = busy_reg;
    assign fin    = busy_reg && (cw.jmp == JMP_DONE) && !hold;

    // next step selection
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = STEP_START;
            end
        end
        else
        begin
            unique case (cw.jmp)
                JMP_NONE:     pc_next = pc_inc;
                JMP_ALWAYS:   pc_next = cw.target;
                JMP_DEN_ZERO: pc_next = st.den_zero ? cw.target : pc_inc;
                JMP_SAT:      pc_next = st.sat ? cw.target : pc_inc;
                JMP_CNT_NZ:   pc_next = st.cnt_nz ? cw.target : pc_inc;
                JMP_DONE:
                begin
                    if (!hold)
                    begin
                        busy_next = 1'b0;
                        pc_next   = STEP_START;
                    end
                end
                default:      pc_next = STEP_START;
            endcase
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= STEP_START;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    // program counter stays inside the program
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= STEP_LAST)
        else $error("step counter left the program");

    // idle sequencer sits at the first step
    a_idle_pc: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> pc_reg == STEP_START)
        else $error("idle sequencer not at first step");

    // a started transaction begins at the first step
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> (busy_reg && pc_reg == STEP_START))
        else $error("start did not enter the program");

endmodule

// ===== hdl/jqpm_dp.sv =====
// datapath: mirror, divide-by-ten unit, squarer, scaling and serial divider
// depends on jqpm_pkg, driven by jqpm_seq control words
module jqpm_dp
    import jqpm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [SAMPLE_BITS-1:0]      sample,
    input  logic [SAMPLE_BITS-1:0]      low_point,
    input  logic [SAMPLE_BITS-1:0]      mid_point,
    input  logic [SAMPLE_BITS-1:0]      high_point,
    input  logic                        flip_axis,
    input  ctl_t                        ctl,
    output stat_t                       st,
    output logic signed [POS_BITS-1:0]  pos
);

    localparam int VW    = SAMPLE_BITS + 2;
    localparam int CW    = SAMPLE_BITS;
    localparam int MW    = SAMPLE_BITS + 1;
    localparam int SHIFT = SAMPLE_BITS + 5;
    localparam int RECIP = (2 ** SHIFT + COARSE_DIV - 1) / COARSE_DIV;
    localparam int PW    = SHIFT + CW;
    localparam int SQW   = 2 * CW - 2;
    localparam int NW    = 2 * SAMPLE_BITS + 5;

    logic [SAMPLE_BITS-1:0]  s_reg;
    logic signed [VW-1:0]    v_reg;
    logic                    low_br_reg;
    logic signed [CW-1:0]    x_reg, xm_reg, xe_reg;
    logic signed [CW-1:0]    q_reg, d_reg;
    logic [NW-1:0]           num_reg, lim_reg, rem_reg, dsh_reg;
    logic [SQW-1:0]          den_reg;
    logic [QUO_BITS-1:0]     quo_reg;
    logic [CNT_BITS-1:0]     cnt_reg;

    logic signed [VW-1:0]    v_mir;
    logic signed [VW-1:0]    c_in;
    logic [MW-1:0]           c_mag;
    logic [PW-1:0]           c_prod;
    logic [CW-1:0]           c_quo;
    logic signed [CW-1:0]    c_out;
    logic signed [CW-1:0]    sq_in;
    logic [CW-1:0]           sq_abs;
    logic [SQW-1:0]          sq_out;
    logic                    ge;
    logic [POS_BITS-1:0]     mag_ext;

    // mirrored or plain sample
    assign v_mir = flip_axis
        ? (VW'(low_point) + VW'(high_point) - VW'(s_reg))
        : VW'(s_reg);

    // divide by ten, truncating toward zero, by reciprocal multiply
    always_comb
    begin
        case (ctl.op)
            OP_COARSE_M: c_in = VW'(mid_point);
            OP_COARSE_E: c_in = low_br_reg ? VW'(low_point) : VW'(high_point);
            default:     c_in = v_reg;
        endcase
    end

    assign c_mag  = c_in[VW-1] ? MW'(-c_in) : MW'(c_in);
    assign c_prod = PW'(c_mag) * PW'(RECIP);
    assign c_quo  = c_prod[SHIFT +: CW];
    assign c_out  = c_in[VW-1] ? -$signed(c_quo) : $signed(c_quo);

    // shared squarer
    assign sq_in  = (ctl.op == OP_SQ_D) ? d_reg : q_reg;
    assign sq_abs = sq_in[CW-1] ? CW'(-sq_in) : CW'(sq_in);
    assign sq_out = SQW'(sq_abs[CW-2:0]) * SQW'(sq_abs[CW-2:0]);

    // restoring divider trial
    assign ge = rem_reg >= dsh_reg;

    // status to sequencer
    assign st.den_zero = (den_reg == '0);
    assign st.sat      = (num_reg >= lim_reg);
    assign st.cnt_nz   = (cnt_reg != '0);

    // signed result
    assign mag_ext = POS_BITS'(quo_reg);
    assign pos     = low_br_reg ? -$signed(mag_ext) : $signed(mag_ext);

    // working registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s_reg <= sample;
        end
        if (ctl.en)
        begin
            case (ctl.op)
                OP_MIRROR:
                begin
                    v_reg      <= v_mir;
                    low_br_reg <= v_mir < $signed(VW'(mid_point));
                end
                OP_COARSE_X: x_reg <= c_out;
                OP_COARSE_M: xm_reg <= c_out;
                OP_COARSE_E: xe_reg <= c_out;
                OP_DIFF:
                begin
                    q_reg <= x_reg - xm_reg;
                    d_reg <= xe_reg - xm_reg;
                end
                OP_SQ_Q:  num_reg <= NW'(sq_out);
                OP_SQ_D:  den_reg <= sq_out;
                OP_SCALE: num_reg <= NW'(num_reg * NW'(POS_MAX));
                OP_LIMIT: lim_reg <= NW'(den_reg) * NW'(SAT_LIMIT);
                OP_DIV_INIT:
                begin
                    rem_reg <= num_reg;
                    dsh_reg <= NW'(den_reg) << (DIV_STEPS - 1);
                    cnt_reg <= CNT_BITS'(DIV_STEPS - 1);
                    quo_reg <= '0;
                end
                OP_DIV_STEP:
                begin
                    if (ge)
                    begin
                        rem_reg <= rem_reg - dsh_reg;
                    end
                    quo_reg <= {quo_reg[QUO_BITS-2:0], ge};
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg - 1'b1;
                end
                OP_ZERO_SPAN:
                begin
                    quo_reg <= (q_reg == '0) ? '0 : QUO_BITS'(POS_MAX);
                end
                OP_SATURATE: quo_reg <= QUO_BITS'(POS_MAX);
                default: ;
            endcase
        end
    end

    // magnitude never exceeds full scale when the result is formed
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.en && ctl.op == OP_SIGN) |-> quo_reg <= QUO_BITS'(POS_MAX))
        else $error("magnitude above full scale");

    // divider loop only entered below the saturation limit
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.en && ctl.op == OP_DIV_STEP && cnt_reg == CNT_BITS'(DIV_STEPS - 1))
        |-> (rem_reg < (dsh_reg << 1)))
        else $error("divider entered with remainder out of range");

endmodule

// ===== hdl/joystick_quadratic_position_map_core.sv =====
// top level of the joystick quadratic position map: config registers, output register
// depends on jqpm_pkg, jqpm_seq and jqpm_dp
//
// channel   direction  handshake                    payload
// sample    in         sample_valid / sample_stall  sample
// result    out        result_valid / result_stall  position, changed
// config    in         cfg_we (write only)          cfg_index, cfg_data
//
// one transaction runs the program steps from acceptance to result: the zero-span step on a
// zero span, the saturate step when saturated, else the seven passes of the serial divider.
// a new sample can be taken in the cycle after the previous result enters the output register.
// a held result (result_stall) parks the sequencer on its last step until it is taken.
// reset clears the sequencer, output valid and last position, and loads the config
// registers with their defaults (low at zero, mid at half scale, high at full scale).
module joystick_quadratic_position_map_core
    import jqpm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_stall,
    input  logic [SAMPLE_BITS-1:0]      sample,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic signed [POS_BITS-1:0]  position,
    output logic                        changed,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [SAMPLE_BITS-1:0]      cfg_data
);

    logic [SAMPLE_BITS-1:0]       low_reg, mid_reg, high_reg;
    logic                         flip_reg;
    logic                         out_valid_reg;
    logic signed [POS_BITS-1:0]   position_reg;
    logic                         changed_reg;
    logic signed [POS_BITS-1:0]   last_reg;
    logic                         busy;
    logic                         fin;
    logic                         start;
    logic                         hold;
    ctl_t                         ctl;
    stat_t                        st;
    logic signed [POS_BITS-1:0]   pos;

    assign sample_stall = busy;
    assign start        = sample_valid && !busy;
    assign hold         = out_valid_reg && result_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            mid_reg  <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
            high_reg <= '1;
            flip_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_LOW:  low_reg  <= cfg_data;
                REG_MID:  mid_reg  <= cfg_data;
                REG_HIGH: high_reg <= cfg_data;
                REG_FLIP: flip_reg <= cfg_data[0];
                default:  ;
            endcase
        end
    end

    // sequencer
    jqpm_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .hold  (hold),
        .st    (st),
        .ctl   (ctl),
        .busy  (busy),
        .fin   (fin)
    );

    // datapath
    jqpm_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (start),
        .sample     (sample),
        .low_point  (low_reg),
        .mid_point  (mid_reg),
        .high_point (high_reg),
        .flip_axis  (flip_reg),
        .ctl        (ctl),
        .st         (st),
        .pos        (pos)
    );

    // output register and last position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_reg      <= '0;
        end
        else
        begin
            if (fin)
            begin
                out_valid_reg <= 1'b1;
                last_reg      <= pos;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            position_reg <= pos;
            changed_reg  <= (pos != last_reg);
        end
    end

    assign result_valid = out_valid_reg;
    assign position     = position_reg;
    assign changed      = changed_reg;

    // a finished transaction never overwrites a held result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> !(out_valid_reg && result_stall))
        else $error("result overwritten while held");

    // last position tracks the delivered result
    a_last_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        fin |=> (last_reg == position_reg && result_valid))
        else $error("last position out of step with result");

    // no new sample while a transaction is in flight
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> sample_stall)
        else $error("sample taken while busy");

endmodule
